### hw/rtl/multi_mode_error_check_generator_defines.svh
// ----------------------------------------------------------------------------
// multi-mode error check generator assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_ERROR_CHECK_GENERATOR_DEFINES_SVH
`define MULTI_MODE_ERROR_CHECK_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMECG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MMECG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mmecg_pkg.sv
// ----------------------------------------------------------------------------
// mmecg_pkg
// widths, method codes, polynomials and per-byte helper functions for the
// multi-mode error check generator
// ----------------------------------------------------------------------------
package mmecg_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned METHOD_W    = 3;
   localparam int unsigned CHECK_W     = 32;
   localparam int unsigned PAIR_W      = 14;
   localparam int unsigned SUM_W       = 16;
   localparam int unsigned RSP_TDATA_W = 48;

   // method register codes
   localparam logic [METHOD_W-1:0] METHOD_EVEN   = 3'd0;
   localparam logic [METHOD_W-1:0] METHOD_ODD    = 3'd1;
   localparam logic [METHOD_W-1:0] METHOD_PAR2D  = 3'd2;
   localparam logic [METHOD_W-1:0] METHOD_CRC8   = 3'd3;
   localparam logic [METHOD_W-1:0] METHOD_CRC16  = 3'd4;
   localparam logic [METHOD_W-1:0] METHOD_CRC32  = 3'd5;
   localparam logic [METHOD_W-1:0] METHOD_HAMM   = 3'd6;
   localparam logic [METHOD_W-1:0] METHOD_CSUM   = 3'd7;

   // crc polynomials and seeds
   localparam logic [7:0]  CRC8_POLY  = 8'h07;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] CRC32_POLY = 32'h04C1_1DB7;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC32_MSB  = 32'h8000_0000;

   typedef logic [CHECK_W-1:0] crc_type;

   // one byte through the crc selected by method, msb first
   function automatic crc_type crc_byte(input logic [METHOD_W-1:0] method,
                                        input crc_type crc,
                                        input logic [DATA_W-1:0] b);
      logic [7:0]  c8;
      logic [15:0] c16;
      logic [31:0] c32;
      crc_type     r;
      c8  = crc[7:0] ^ b;
      c16 = crc[15:0] ^ {b, 8'h00};
      c32 = crc ^ {b, 24'h000000};
      for (int j = 0; j < 8; j++) begin
         c8  = c8[7] ? ({c8[6:0], 1'b0} ^ CRC8_POLY) : {c8[6:0], 1'b0};
         c16 = c16[15] ? ({c16[14:0], 1'b0} ^ CRC16_POLY) : {c16[14:0], 1'b0};
         c32 = ((c32 & CRC32_MSB) != 32'h0) ? ({c32[30:0], 1'b0} ^ CRC32_POLY)
                                              : {c32[30:0], 1'b0};
      end
      case (method)
         METHOD_CRC8:  r = {24'h000000, c8};
         METHOD_CRC16: r = {16'h0000, c16};
         METHOD_CRC32: r = c32;
         default:      r = crc;
      endcase
      return r;
   endfunction

   // hamming(7,4): p1 p2 d1 p3 d2 d3 d4 with p1 in bit 6
   function automatic logic [6:0] ham_nibble(input logic [3:0] n);
      logic p1;
      logic p2;
      logic p3;
      p1 = n[3] ^ n[2] ^ n[0];
      p2 = n[3] ^ n[1] ^ n[0];
      p3 = n[2] ^ n[1] ^ n[0];
      return {p1, p2, n[3], p3, n[2], n[1], n[0]};
   endfunction

   // ones-complement add with end-around carry
   function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] sum,
                                                input logic [SUM_W-1:0] w);
      logic [SUM_W:0] s;
      s = {1'b0, sum} + {1'b0, w};
      return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
   endfunction

endpackage

### hw/rtl/multi_mode_error_check_generator.sv
// Path: an accepted byte is captured in the input register and its result, if
//   any, in the result register; a byte that gives no result only updates
//   state.
// Throughput: one byte per cycle unless a held result is stalled by rsp_tready;
//   the 8-step crc update is flat xor logic between the input register and the result register.
// Reset (synchronous, active high) clears the method to even parity, all
//   accumulators, the message-open flag and both valid flags.
// ----------------------------------------------------------------------------
// multi_mode_error_check_generator
// streams a message a byte at a time and builds parity, 2d parity, crc,
// hamming codewords or the internet checksum as chosen by the method register
// ----------------------------------------------------------------------------
module multi_mode_error_check_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // method register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mmecg_pkg::METHOD_W-1:0]        csr_data,
   // message bytes
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mmecg_pkg::DATA_W-1:0]          req_tdata,  // [7:0] data_byte
   input  logic                                  req_tuser,  // [0] byte_present
   input  logic                                  req_tlast,  // last_byte
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] check_value, [45:32] codeword_pair, [46] row_parity, [47] zero
   output logic [mmecg_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tlast   // final_result
);

   // method register
   logic [mmecg_pkg::METHOD_W-1:0] method_ff;

   // input stage
   logic                           in_vld_ff;
   logic [mmecg_pkg::DATA_W-1:0]   in_byte_ff;
   logic                           in_present_ff;
   logic                           in_last_ff;

   // message state
   logic [mmecg_pkg::CHECK_W-1:0]  crc_ff,     crc_in;
   logic [mmecg_pkg::SUM_W-1:0]    sum_ff,     sum_in;
   logic [mmecg_pkg::DATA_W-1:0]   held_ff,    held_in;
   logic                           pending_ff, pending_in;
   logic [mmecg_pkg::DATA_W-1:0]   col_ff,     col_in;
   logic                           runpar_ff,  runpar_in;
   logic                           open_ff,    open_in;

   // result stage
   logic                               rsp_vld_ff;
   logic [mmecg_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                               rsp_last_ff;

   logic adv;
   logic emit;

   assign csr_ready  = 1'b1;
   assign adv        = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // method register write
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= mmecg_pkg::METHOD_EVEN;
      end else if (csr_valid && csr_ready) begin
         method_ff <= csr_data;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
   end

   // per-byte update and result assembly
   always_comb begin
      logic [mmecg_pkg::CHECK_W-1:0] crc_base;
      logic [mmecg_pkg::SUM_W-1:0]   sum_base;
      logic [mmecg_pkg::DATA_W-1:0]  held_base;
      logic                          pending_base;
      logic [mmecg_pkg::DATA_W-1:0]  col_base;
      logic                          runpar_base;
      logic                          row_bit;
      logic                          add_en;
      logic [mmecg_pkg::SUM_W-1:0]   add_word;
      logic [mmecg_pkg::CHECK_W-1:0] check;
      logic [mmecg_pkg::PAIR_W-1:0]  pair;
      logic                          row_out;

      // a new message starts from cleared state and the method's crc seed
      if (open_ff) begin
         crc_base     = crc_ff;
         sum_base     = sum_ff;
         held_base    = held_ff;
         pending_base = pending_ff;
         col_base     = col_ff;
         runpar_base  = runpar_ff;
      end else begin
         case (method_ff)
            mmecg_pkg::METHOD_CRC16: crc_base = {16'h0000, mmecg_pkg::CRC16_INIT};
            mmecg_pkg::METHOD_CRC32: crc_base = mmecg_pkg::CRC32_INIT;
            default:                 crc_base = '0;
         endcase
         sum_base     = '0;
         held_base    = '0;
         pending_base = 1'b0;
         col_base     = '0;
         runpar_base  = 1'b0;
      end

      row_bit = ^in_byte_ff;

      // fold in the byte
      crc_in     = crc_base;
      runpar_in  = runpar_base;
      col_in     = col_base;
      held_in    = held_base;
      pending_in = pending_base;
      add_en     = 1'b0;
      add_word   = '0;
      if (in_present_ff) begin
         crc_in    = mmecg_pkg::crc_byte(method_ff, crc_base, in_byte_ff);
         runpar_in = runpar_base ^ row_bit;
         col_in    = col_base ^ in_byte_ff;
         if (pending_base) begin
            add_en     = 1'b1;
            add_word   = {held_base, in_byte_ff};
            held_in    = '0;
            pending_in = 1'b0;
         end else begin
            held_in    = in_byte_ff;
            pending_in = 1'b1;
            // odd final byte padded with zero
            add_en     = in_last_ff && (method_ff == mmecg_pkg::METHOD_CSUM);
            add_word   = {in_byte_ff, 8'h00};
         end
      end else if (in_last_ff && pending_base &&
                   (method_ff == mmecg_pkg::METHOD_CSUM)) begin
         add_en   = 1'b1;
         add_word = {held_base, 8'h00};
      end
      sum_in = add_en ? mmecg_pkg::sum_add(sum_base, add_word) : sum_base;

      // final check value
      check = '0;
      if (in_last_ff) begin
         case (method_ff)
            mmecg_pkg::METHOD_EVEN:  check = {31'h0, runpar_in};
            mmecg_pkg::METHOD_ODD:   check = {31'h0, ~runpar_in};
            mmecg_pkg::METHOD_PAR2D: check = {24'h000000, col_in};
            mmecg_pkg::METHOD_CRC8:  check = {24'h000000, crc_in[7:0]};
            mmecg_pkg::METHOD_CRC16: check = {16'h0000, crc_in[15:0]};
            mmecg_pkg::METHOD_CRC32: check = ~crc_in;
            mmecg_pkg::METHOD_CSUM:  check = {16'h0000, ~sum_in};
            default:                 check = '0;
         endcase
      end

      // per-byte fields
      pair    = '0;
      row_out = 1'b0;
      if (in_present_ff && (method_ff == mmecg_pkg::METHOD_HAMM)) begin
         pair = {mmecg_pkg::ham_nibble(in_byte_ff[7:4]),
                 mmecg_pkg::ham_nibble(in_byte_ff[3:0])};
      end
      if (in_present_ff && (method_ff == mmecg_pkg::METHOD_PAR2D)) begin
         row_out = row_bit;
      end

      emit = in_last_ff ||
             (in_present_ff && ((method_ff == mmecg_pkg::METHOD_PAR2D) ||
                                (method_ff == mmecg_pkg::METHOD_HAMM)));
      rsp_data_in = {1'b0, row_out, pair, check};

      // state after this item
      if (in_last_ff) begin
         crc_in     = '0;
         sum_in     = '0;
         held_in    = '0;
         pending_in = 1'b0;
         col_in     = '0;
         runpar_in  = 1'b0;
         open_in    = 1'b0;
      end else if (in_present_ff) begin
         open_in    = 1'b1;
      end else begin
         crc_in     = crc_ff;
         sum_in     = sum_ff;
         held_in    = held_ff;
         pending_in = pending_ff;
         col_in     = col_ff;
         runpar_in  = runpar_ff;
         open_in    = open_ff;
      end
   end

   // message state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= '0;
         sum_ff     <= '0;
         held_ff    <= '0;
         pending_ff <= 1'b0;
         col_ff     <= '0;
         runpar_ff  <= 1'b0;
         open_ff    <= 1'b0;
      end else if (adv) begin
         crc_ff     <= crc_in;
         sum_ff     <= sum_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         col_ff     <= col_in;
         runpar_ff  <= runpar_in;
         open_ff    <= open_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv && emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= in_last_ff;
      end
   end

endmodule

### hw/rtl/mmecg_checker.sv
// ----------------------------------------------------------------------------
// mmecg_checker
// port-level checks on the result channel of the error check generator
// ----------------------------------------------------------------------------
`include "multi_mode_error_check_generator_defines.svh"

module mmecg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [mmecg_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic                                 rsp_tlast
);

   // a stalled result stays offered
   `MMECG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // a stalled result keeps its payload
   `MMECG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // check value only on the final result of a message
   `MMECG_ASSERT_IMPLY(a_check_final, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[31:0] == 32'h0, "check value on a non-final result")

   // row parity and hamming codewords never share a result, pad bit is zero
   `MMECG_ASSERT_IMPLY(a_mode_fields, clock, reset, rsp_tvalid, !rsp_tdata[47] && !(rsp_tdata[46] && (rsp_tdata[45:32] != 14'h0)), "mixed mode fields in result")

   // nothing offered right after reset
   `MMECG_ASSERT_IMPLY(a_reset_idle, clock, 1'b0, $past(reset) && !reset, !rsp_tvalid, "result valid after reset")

endmodule

bind multi_mode_error_check_generator mmecg_checker u_mmecg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### tb/multi_mode_error_check_generator_test.sv
// ----------------------------------------------------------------------------
// multi_mode_error_check_generator_test
// streams directed and random messages through every check method, predicts
// parity, 2d parity, crc, hamming codewords and checksum per transfer and
// compares each result field by field under random idling on both channels
// ----------------------------------------------------------------------------
module multi_mode_error_check_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 200;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 55;

   typedef struct packed {
      logic [mmecg_pkg::DATA_W-1:0] data_byte;
      logic                         byte_present;
      logic                         last_byte;
   } message_item_type;

   typedef struct packed {
      logic [mmecg_pkg::CHECK_W-1:0] check_value;
      logic [mmecg_pkg::PAIR_W-1:0]  codeword_pair;
      logic                          row_parity;
      logic                          final_result;
   } check_result_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [mmecg_pkg::METHOD_W-1:0]    csr_data = mmecg_pkg::METHOD_EVEN;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [mmecg_pkg::DATA_W-1:0]      req_tdata = '0;   // [7:0] data_byte
   logic                              req_tuser = 1'b0; // [0] byte_present
   logic                              req_tlast = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // [31:0] check_value, [45:32] codeword_pair, [46] row_parity, [47] zero
   logic [mmecg_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tlast;

   multi_mode_error_check_generator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // message bytes waiting to be sent and results still owed by the block
   message_item_type pending_items[$];
   check_result_type expected_checks[$];

   // predictor copy of the method register and the running checks
   logic [mmecg_pkg::METHOD_W-1:0] cur_method = mmecg_pkg::METHOD_EVEN;
   logic [31:0]                    crc_acc = '0;
   logic [mmecg_pkg::SUM_W-1:0]    sum_acc = '0;
   logic [7:0]                     held_hi = '0;
   logic                           half_pending = 1'b0;
   logic [7:0]                     col_par = '0;
   logic                           run_par = 1'b0;
   logic                           msg_open = 1'b0;

   message_item_type offered_item;
   check_result_type predicted;
   bit               idle_on = 1'b1;
   int               send_gap = 0;
   int               recv_gap = 0;
   int               accepted_items = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               cycle_count = 0;
   int               mismatch_count = 0;
   int               msg_left = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // short gaps mostly, now and then a long one
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] random_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void clear_checks();
      crc_acc      = '0;
      sum_acc      = '0;
      held_hi      = '0;
      half_pending = 1'b0;
      col_par      = '0;
      run_par      = 1'b0;
      msg_open     = 1'b0;
   endfunction

   // msb-first crc over one byte, width and polynomial from the method
   function automatic logic [31:0] crc_step(input logic [mmecg_pkg::METHOD_W-1:0] m,
                                            input logic [31:0] acc,
                                            input logic [7:0] b);
      logic [31:0] r;
      logic [31:0] poly;
      logic [31:0] top;
      logic [31:0] mask;
      case (m)
         mmecg_pkg::METHOD_CRC8: begin
            mask = 32'h0000_00FF;
            poly = {24'h0, mmecg_pkg::CRC8_POLY};
            r    = (acc ^ {24'h0, b}) & mask;
         end
         mmecg_pkg::METHOD_CRC16: begin
            mask = 32'h0000_FFFF;
            poly = {16'h0, mmecg_pkg::CRC16_POLY};
            r    = (acc ^ {16'h0, b, 8'h0}) & mask;
         end
         mmecg_pkg::METHOD_CRC32: begin
            mask = 32'hFFFF_FFFF;
            poly = mmecg_pkg::CRC32_POLY;
            r    = acc ^ {b, 24'h0};
         end
         default: return acc;
      endcase
      top = (mask >> 1) + 32'h1;
      for (int j = 0; j < 8; j++) begin
         if ((r & top) != 32'h0) r = ((r << 1) ^ poly) & mask;
         else r = (r << 1) & mask;
      end
      return r;
   endfunction

   // codeword p1 p2 d1 p3 d2 d3 d4, d1 being nibble bit 3
   function automatic logic [6:0] hamming7(input logic [3:0] n);
      logic p1;
      logic p2;
      logic p3;
      p1 = ^(n & 4'b1101);
      p2 = ^(n & 4'b1011);
      p3 = ^(n & 4'b0111);
      return {p1, p2, n[3], p3, n[2:0]};
   endfunction

   // ones-complement 16-bit add with end-around carry
   function automatic logic [mmecg_pkg::SUM_W-1:0] ones_add(
         input logic [mmecg_pkg::SUM_W-1:0] a,
         input logic [mmecg_pkg::SUM_W-1:0] w);
      logic [mmecg_pkg::SUM_W:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[mmecg_pkg::SUM_W-1:0] + {{(mmecg_pkg::SUM_W-1){1'b0}}, s[mmecg_pkg::SUM_W]};
   endfunction

   // fold one accepted transfer into the checks, return 1 when a result is due
   function automatic bit encode_item(input message_item_type item,
                                      output check_result_type res);
      logic row;
      bit   emit;
      res  = '0;
      row  = 1'b0;
      emit = 1'b0;
      if (!item.byte_present && !item.last_byte) return 1'b0;
      if (!msg_open) begin
         clear_checks();
         if (cur_method == mmecg_pkg::METHOD_CRC16) crc_acc = {16'h0, mmecg_pkg::CRC16_INIT};
         else if (cur_method == mmecg_pkg::METHOD_CRC32) crc_acc = mmecg_pkg::CRC32_INIT;
         msg_open = 1'b1;
      end
      if (item.byte_present) begin
         row     = ^item.data_byte;
         run_par = run_par ^ row;
         col_par = col_par ^ item.data_byte;
         crc_acc = crc_step(cur_method, crc_acc, item.data_byte);
         if (half_pending) begin
            sum_acc      = ones_add(sum_acc, {held_hi, item.data_byte});
            half_pending = 1'b0;
            held_hi      = '0;
         end else begin
            held_hi      = item.data_byte;
            half_pending = 1'b1;
         end
         if (cur_method == mmecg_pkg::METHOD_HAMM)
            res.codeword_pair = {hamming7(item.data_byte[7:4]),
                                 hamming7(item.data_byte[3:0])};
         if (cur_method == mmecg_pkg::METHOD_PAR2D || cur_method == mmecg_pkg::METHOD_HAMM)
            emit = 1'b1;
      end
      if (cur_method == mmecg_pkg::METHOD_PAR2D) res.row_parity = row;
      if (item.last_byte) begin
         emit = 1'b1;
         case (cur_method)
            mmecg_pkg::METHOD_EVEN:  res.check_value = {31'h0, run_par};
            mmecg_pkg::METHOD_ODD:   res.check_value = {31'h0, ~run_par};
            mmecg_pkg::METHOD_PAR2D: res.check_value = {24'h0, col_par};
            mmecg_pkg::METHOD_CRC8:  res.check_value = crc_acc & 32'h0000_00FF;
            mmecg_pkg::METHOD_CRC16: res.check_value = crc_acc & 32'h0000_FFFF;
            mmecg_pkg::METHOD_CRC32: res.check_value = ~crc_acc;
            mmecg_pkg::METHOD_CSUM: begin
               if (half_pending) sum_acc = ones_add(sum_acc, {held_hi, 8'h00});
               res.check_value = {16'h0, ~sum_acc};
            end
            default:                 res.check_value = '0;
         endcase
         clear_checks();
      end
      res.final_result = item.last_byte;
      return emit;
   endfunction

   // sender: offers queued bytes, predicts each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
         clear_checks();
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_items <= accepted_items + 1;
            if (encode_item(offered_item, predicted)) expected_checks.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               offered_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered_item.data_byte;
               req_tuser  <= offered_item.byte_present;
               req_tlast  <= offered_item.last_byte;
               if (idle_on) send_gap = random_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // receiver: checks each result transfer against the oldest prediction
   always @(posedge clock) begin
      check_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_checks.size() == 0) begin
               $display("%0t: unexpected result expected none actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_checks.pop_front();
               compare_field("check_value", want.check_value, rsp_tdata[31:0]);
               compare_field("codeword_pair", 32'(want.codeword_pair),
                             32'(rsp_tdata[45:32]));
               compare_field("row_parity", 32'(want.row_parity), 32'(rsp_tdata[46]));
               compare_field("tdata pad", 32'h0, 32'(rsp_tdata[47]));
               compare_field("final_result", 32'(want.final_result), 32'(rsp_tlast));
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap = recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on) recv_gap = random_gap();
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_items >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] b, input logic present, input logic last);
      message_item_type item;
      item.data_byte    = b;
      item.byte_present = present;
      item.last_byte    = last;
      pending_items.push_back(item);
   endtask

   // method register write, returns on a falling edge
   task automatic write_method(input logic [mmecg_pkg::METHOD_W-1:0] m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_method = m;
      @(negedge clock);
   endtask

   // all bytes sent, all results back, then room for byte-only transfers
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_checks.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // well-formed messages mostly, some empty, byte-less endings and noise;
   // messages may run across phases so the method changes mid-message
   task automatic queue_random_items(input int count);
      int made;
      int roll;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (msg_left == 0) begin
            if (roll < 6) begin
               push_item(random_byte(), 1'b0, 1'b0);
            end else if (roll < 10) begin
               push_item(random_byte(), 1'b0, 1'b1);
               made++;
            end else begin
               msg_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48)
                                                       : $urandom_range(1, 8);
            end
         end else begin
            msg_left = msg_left - 1;
            if (msg_left != 0) begin
               push_item(random_byte(), 1'b1, 1'b0);
               made++;
            end else if (roll < 8) begin
               push_item(random_byte(), 1'b1, 1'b0);
               push_item(random_byte(), 1'b0, 1'b1);
               made += 2;
            end else begin
               push_item(random_byte(), 1'b1, 1'b1);
               made++;
            end
         end
      end
   endtask

   initial begin
      logic [mmecg_pkg::METHOD_W-1:0] phase_methods [RANDOM_PHASES] = '{
         mmecg_pkg::METHOD_CSUM, mmecg_pkg::METHOD_CRC32, mmecg_pkg::METHOD_EVEN,
         mmecg_pkg::METHOD_HAMM, mmecg_pkg::METHOD_PAR2D, mmecg_pkg::METHOD_CRC8,
         mmecg_pkg::METHOD_ODD, mmecg_pkg::METHOD_CRC16, mmecg_pkg::METHOD_CSUM,
         mmecg_pkg::METHOD_EVEN};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, empty messages, noise, odd checksum pad
      write_method(mmecg_pkg::METHOD_EVEN);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b1);
      wait_drained();
      write_method(mmecg_pkg::METHOD_ODD);
      push_item(8'h80, 1'b1, 1'b1);
      push_item(8'h55, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      wait_drained();
      write_method(mmecg_pkg::METHOD_PAR2D);
      push_item(8'h01, 1'b1, 1'b0);
      push_item(8'hFE, 1'b1, 1'b1);
      push_item(8'h7F, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      wait_drained();
      write_method(mmecg_pkg::METHOD_CRC8);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      wait_drained();
      // message left open across method changes: crc16 into crc32 into crc8
      write_method(mmecg_pkg::METHOD_CRC16);
      push_item(8'h31, 1'b1, 1'b1);
      push_item(8'hFF, 1'b1, 1'b0);
      wait_drained();
      write_method(mmecg_pkg::METHOD_CRC32);
      push_item(8'h5A, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      wait_drained();
      write_method(mmecg_pkg::METHOD_CRC8);
      push_item(8'h01, 1'b1, 1'b1);
      wait_drained();
      write_method(mmecg_pkg::METHOD_HAMM);
      push_item(8'hF0, 1'b1, 1'b0);
      push_item(8'h0F, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b1);
      wait_drained();
      write_method(mmecg_pkg::METHOD_CSUM);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b0);
      push_item(8'h01, 1'b1, 1'b1);
      push_item(8'hAB, 1'b1, 1'b0);
      push_item(8'hCD, 1'b1, 1'b1);
      push_item(8'h00, 1'b0, 1'b1);
      wait_drained();

      // random phases, some without any idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = (p % 3) != 2;
         write_method(phase_methods[p]);
         queue_random_items(PHASE_ITEMS);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### multi_mode_error_check_generator.f
+incdir+hw/rtl
hw/rtl/mmecg_pkg.sv
hw/rtl/multi_mode_error_check_generator.sv
hw/rtl/mmecg_checker.sv
tb/multi_mode_error_check_generator_test.sv
